/* rtl/tkv_pkg.sv */
// tkv_pkg: shared types, codes and widths for the tagged key/value map
// no dependencies; used by tkv_key_match and tagged_key_value_map
`default_nettype none

package tkv_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int REQ_W  = 3;
  localparam int TAG_W  = 3;
  localparam int PAY_W  = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [REQ_W-1:0] REQ_PUT      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COUNT    = 3'd4;

  localparam logic [TAG_W-1:0] TAG_FLOAT = 3'd1;

  localparam logic [PAY_W-1:0] FLOAT_MAG_MASK = 32'h7FFF_FFFF;
  localparam logic [PAY_W-1:0] FLOAT_INF      = 32'h7F80_0000;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PAY_W-1:0] word;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VREAD,
    ST_VWAIT,
    ST_MREAD,
    ST_MWRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/tkv_ram.sv */
// tkv_ram: generic single write, single read RAM with registered read data
// no package dependency
`default_nettype none

module tkv_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tkv_key_match.sv */
// tkv_key_match: compare unit shared by every slot probe of a scan
// depends on tkv_pkg for tag codes and float masks
`default_nettype none

module tkv_key_match (
  input  wire logic [tkv_pkg::TAG_W-1:0] tag_a,
  input  wire logic [tkv_pkg::PAY_W-1:0] pay_a,
  input  wire logic [tkv_pkg::TAG_W-1:0] tag_b,
  input  wire logic [tkv_pkg::PAY_W-1:0] pay_b,
  output      logic                      match
);

  import tkv_pkg::*;

  logic nan_a;
  logic nan_b;
  logic zero_both;

  assign nan_a     = (pay_a & FLOAT_MAG_MASK) > FLOAT_INF;
  assign nan_b     = (pay_b & FLOAT_MAG_MASK) > FLOAT_INF;
  assign zero_both = ((pay_a & FLOAT_MAG_MASK) == '0) && ((pay_b & FLOAT_MAG_MASK) == '0);

  always_comb begin
    if (tag_a != tag_b) begin
      match = 1'b0;
    end else if (tag_a == TAG_FLOAT) begin
      match = !nan_a && !nan_b && (zero_both || (pay_a == pay_b));
    end else begin
      match = (pay_a == pay_b);
    end
  end

endmodule

`default_nettype wire

/* rtl/tagged_key_value_map.sv */
// Associative map of tagged keys to tagged values. A request is taken when start is high and
// busy is low; its single result appears for exactly one cycle with done high and cannot be
// held off by the receiver. Entries are kept packed in slots 0 to count-1 of a key memory and
// a value memory, so the table is empty straight out of reset with no clearing pass. Put, get,
// contains and remove scan the occupied slots one per cycle through the key memory read port
// and the shared key compare unit. A get that hits then reads the value memory in the VREAD
// and VWAIT states, and a remove that has to move the last entry into the freed slot does so
// in the MREAD and MWRITE states. An entry count request or an unused code goes straight from
// idle to the done state. The default table holds 64 entries.
// depends on tkv_pkg, tkv_ram and tkv_key_match
`default_nettype none

module tagged_key_value_map #(
  parameter int TABLE_ENTRIES = tkv_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [tkv_pkg::REQ_W-1:0]     req_type,
  input  wire logic [tkv_pkg::TAG_W-1:0]     key_tag,
  input  wire logic [tkv_pkg::PAY_W-1:0]     key_payload,
  input  wire logic [tkv_pkg::TAG_W-1:0]     value_tag,
  input  wire logic [tkv_pkg::PAY_W-1:0]     value_payload,
  output      logic                          done,
  output      logic                          found,
  output      logic [tkv_pkg::TAG_W-1:0]     result_tag,
  output      logic [tkv_pkg::PAY_W-1:0]     result_payload,
  output      logic [tkv_pkg::CNT_OUT_W-1:0] entry_count,
  output      logic                          status
);

  import tkv_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  state_t state, state_next;

  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    scan_addr, scan_addr_next;
  logic             rd_valid, rd_valid_next;
  logic [AW-1:0]    hit_idx, hit_idx_next;
  logic [AW-1:0]    pos, pos_next;

  logic [REQ_W-1:0] cur_req, cur_req_next;
  entry_t           cur_key, cur_key_next;
  entry_t           cur_value, cur_value_next;

  logic             found_next;
  logic [TAG_W-1:0] result_tag_next;
  logic [PAY_W-1:0] result_payload_next;
  logic             status_next;

  logic             key_we;
  logic [AW-1:0]    key_waddr;
  entry_t           key_wdata;
  logic [AW-1:0]    key_raddr;
  entry_t           key_rdata;

  logic             val_we;
  logic [AW-1:0]    val_waddr;
  entry_t           val_wdata;
  logic [AW-1:0]    val_raddr;
  entry_t           val_rdata;

  logic             key_hit;
  logic [AW-1:0]    last_idx;

  tkv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  tkv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  tkv_key_match u_match (
    .tag_a (key_rdata.tag),
    .pay_a (key_rdata.word),
    .tag_b (cur_key.tag),
    .pay_b (cur_key.word),
    .match (key_hit)
  );

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_DONE);
  assign entry_count = CNT_OUT_W'(count);
  assign last_idx    = AW'(count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
    end
    scan_addr      <= scan_addr_next;
    hit_idx        <= hit_idx_next;
    pos            <= pos_next;
    cur_req        <= cur_req_next;
    cur_key        <= cur_key_next;
    cur_value      <= cur_value_next;
    found          <= found_next;
    result_tag     <= result_tag_next;
    result_payload <= result_payload_next;
    status         <= status_next;
  end

  always_comb begin
    state_next          = state;
    count_next          = count;
    scan_addr_next      = scan_addr;
    rd_valid_next       = rd_valid;
    hit_idx_next        = hit_idx;
    pos_next            = pos;
    cur_req_next        = cur_req;
    cur_key_next        = cur_key;
    cur_value_next      = cur_value;
    found_next          = found;
    result_tag_next     = result_tag;
    result_payload_next = result_payload;
    status_next         = status;

    key_we    = 1'b0;
    key_waddr = pos;
    key_wdata = key_rdata;
    key_raddr = scan_addr[AW-1:0];
    val_we    = 1'b0;
    val_waddr = pos;
    val_wdata = val_rdata;
    val_raddr = pos;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_req_next        = req_type;
          cur_key_next        = '{tag: key_tag, word: key_payload};
          cur_value_next      = '{tag: value_tag, word: value_payload};
          found_next          = 1'b0;
          result_tag_next     = '0;
          result_payload_next = '0;
          status_next         = 1'b0;
          scan_addr_next      = '0;
          rd_valid_next       = 1'b0;
          if (req_type inside {[REQ_PUT:REQ_REMOVE]}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        if (rd_valid && key_hit) begin
          pos_next      = hit_idx;
          found_next    = 1'b1;
          rd_valid_next = 1'b0;
          case (cur_req)
            REQ_PUT: begin
              val_we     = 1'b1;
              val_waddr  = hit_idx;
              val_wdata  = cur_value;
              state_next = ST_DONE;
            end
            REQ_GET: begin
              state_next = ST_VREAD;
            end
            REQ_REMOVE: begin
              if (hit_idx == last_idx) begin
                count_next = CW'(count - CW'(1));
                state_next = ST_DONE;
              end else begin
                state_next = ST_MREAD;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end else if (!rd_valid && (scan_addr >= count)) begin
          // key absent
          if (cur_req == REQ_PUT) begin
            if (count == FULL) begin
              status_next = 1'b1;
            end else begin
              key_we     = 1'b1;
              key_waddr  = count[AW-1:0];
              key_wdata  = cur_key;
              val_we     = 1'b1;
              val_waddr  = count[AW-1:0];
              val_wdata  = cur_value;
              count_next = CW'(count + CW'(1));
            end
          end
          state_next = ST_DONE;
        end else if (scan_addr < count) begin
          rd_valid_next  = 1'b1;
          hit_idx_next   = scan_addr[AW-1:0];
          scan_addr_next = CW'(scan_addr + CW'(1));
        end else begin
          rd_valid_next = 1'b0;
        end
      end

      ST_VREAD: begin
        state_next = ST_VWAIT;
      end

      ST_VWAIT: begin
        result_tag_next     = val_rdata.tag;
        result_payload_next = val_rdata.word;
        state_next          = ST_DONE;
      end

      ST_MREAD: begin
        // fetch the last entry to fill the freed slot
        key_raddr  = last_idx;
        val_raddr  = last_idx;
        state_next = ST_MWRITE;
      end

      ST_MWRITE: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        count_next = CW'(count - CW'(1));
        state_next = ST_DONE;
      end

      ST_DONE: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count above table size");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_refused_absent : assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!found && (count == FULL) && (cur_req == REQ_PUT)))
    else $error("refusal on a found key or non-full table");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer accepted without going busy");

endmodule

`default_nettype wire
